[rtl/dstp_pkg.sv]
// Package for the decimal scientific text parser: character codes, limits,
// field widths and the parser phase type. No dependencies.
`default_nettype none

package dstp_pkg;

  localparam int unsigned MANT_DIGITS = 18;
  localparam int unsigned MANT_W      = 60;
  localparam int unsigned SIG_W       = 5;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned EXPV_W      = 14;
  localparam int unsigned EXPO_W      = 15;
  localparam int unsigned OUT_W       = 80;

  localparam logic [CNT_W-1:0]  COUNT_MAX = 8'd255;
  localparam logic [EXPV_W-1:0] EXP_MAX   = 14'd16383;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_E_LO  = 8'h65;

  typedef enum logic [6:0] {
    PH_SKIP    = 7'b0000001,
    PH_INT     = 7'b0000010,
    PH_FRAC    = 7'b0000100,
    PH_EXPSIGN = 7'b0001000,
    PH_EXPDIG  = 7'b0010000,
    PH_DONE    = 7'b0100000,
    PH_WAIT    = 7'b1000000
  } phase_e;

endpackage

`default_nettype wire

[rtl/decimal_scientific_text_parser_top.sv]
// Top level of the decimal scientific text parser: input register, parser
// state update and result register. Depends on dstp_pkg.
`default_nettype none

// Takes one text byte per word and returns one result word per string, at
// its final byte or at the first NUL byte. A byte passes the input register,
// then the parser update that writes the result register. A new byte is
// taken every cycle while the result side keeps up; only a byte that emits a
// result (a string end or the first NUL) waits for the result register.
// Result: mantissa of up to 18 significant digits, net decimal exponent
// clamped to +-16383, and flags for dropped digits and saturation. Bytes
// after a NUL up to the end of that string are discarded.
module decimal_scientific_text_parser_top
  import dstp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [7:0]       s_axis_tdata_i,   // [7:0] char_code
  input  wire logic             s_axis_tlast_i,   // string_end
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // [0] negative, [60:1] mantissa, [75:61] decimal_exponent,
  // [76] digits_dropped, [77] exponent_saturated, [79:78] zero
  output logic [OUT_W-1:0]      m_axis_tdata_o
);

  // input register
  logic             in_valid_q;
  logic [7:0]       in_char_q;
  logic             in_last_q;

  // parser state
  phase_e            phase_q, phase_p, phase_d;
  logic              minus_q, minus_p;
  logic [MANT_W-1:0] acc_q, acc_p;
  logic [SIG_W-1:0]  sig_q, sig_p;
  logic [CNT_W-1:0]  frac_q, frac_p;
  logic [CNT_W-1:0]  drop_q, drop_p;
  logic [EXPV_W-1:0] expv_q, expv_p;
  logic              exp_minus_q, exp_minus_p;
  logic              dropped_q, dropped_p;
  logic              sat_q, sat_p;

  // result register
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q, out_data_d;

  logic              is_digit, is_space, is_sign, is_e, is_dot, is_nul;
  logic [3:0]        digit;
  logic              parse_en, take_mant, take_exp, in_frac;
  phase_e            ph_eff;
  logic [MANT_W+3:0] acc_ten;
  logic [17:0]       exp_prod;
  logic signed [16:0] exp_s, exp_net, exp_clamp;
  logic              sat_out;
  logic              emit_now, out_free, advance;

  localparam logic signed [16:0] ExpMaxS = 17'sd16383;

  assign is_nul   = (in_char_q == CH_NUL);
  assign is_digit = (in_char_q >= CH_ZERO) && (in_char_q <= CH_NINE);
  assign is_space = (in_char_q == CH_SPACE) || ((in_char_q >= CH_TAB) && (in_char_q <= CH_CR));
  assign is_sign  = (in_char_q == CH_PLUS) || (in_char_q == CH_MINUS);
  assign is_e     = (in_char_q == CH_E_LO) || (in_char_q == CH_E_UP);
  assign is_dot   = (in_char_q == CH_DOT);
  assign digit    = in_char_q[3:0];

  assign parse_en = (phase_q != PH_WAIT) && !is_nul;
  assign acc_ten  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0};
  assign exp_prod = {1'b0, expv_q, 3'b000} + {3'b000, expv_q, 1'b0} + {14'd0, digit};

  always_comb begin
    phase_p     = phase_q;
    minus_p     = minus_q;
    acc_p       = acc_q;
    sig_p       = sig_q;
    frac_p      = frac_q;
    drop_p      = drop_q;
    expv_p      = expv_q;
    exp_minus_p = exp_minus_q;
    dropped_p   = dropped_q;
    sat_p       = sat_q;
    take_mant   = 1'b0;
    take_exp    = 1'b0;
    in_frac     = 1'b0;

    // a non-blank, non-sign byte in the blank phase is read as an integer byte
    ph_eff = phase_q;
    if (phase_q == PH_SKIP && !is_space && !is_sign) begin
      ph_eff = PH_INT;
      phase_p = PH_INT;
    end

    if (parse_en) begin
      case (ph_eff)
        PH_SKIP: begin
          if (is_sign) begin
            minus_p = (in_char_q == CH_MINUS);
            phase_p = PH_INT;
          end
        end
        PH_INT: begin
          if (is_digit) take_mant = 1'b1;
          else if (is_dot) phase_p = PH_FRAC;
          else if (is_e) phase_p = PH_EXPSIGN;
          else phase_p = PH_DONE;
        end
        PH_FRAC: begin
          if (is_digit) begin
            take_mant = 1'b1;
            in_frac   = 1'b1;
          end else if (is_e) phase_p = PH_EXPSIGN;
          else phase_p = PH_DONE;
        end
        PH_EXPSIGN: begin
          if (is_sign) begin
            exp_minus_p = (in_char_q == CH_MINUS);
            phase_p     = PH_EXPDIG;
          end else if (is_digit) begin
            take_exp = 1'b1;
            phase_p  = PH_EXPDIG;
          end else phase_p = PH_DONE;
        end
        PH_EXPDIG: begin
          if (is_digit) take_exp = 1'b1;
          else phase_p = PH_DONE;
        end
        default: ;
      endcase
    end else begin
      phase_p = phase_q;
    end

    if (take_mant) begin
      if (acc_q == '0 && digit == 4'd0) begin
        // leading zero: no capacity used, still scales in the fraction
        if (in_frac) begin
          if (frac_q == COUNT_MAX) sat_p = 1'b1;
          else frac_p = frac_q + 1'b1;
        end
      end else if (sig_q < SIG_W'(MANT_DIGITS)) begin
        acc_p = acc_ten[MANT_W-1:0] + {{(MANT_W-4){1'b0}}, digit};
        sig_p = sig_q + 1'b1;
        if (in_frac) begin
          if (frac_q == COUNT_MAX) sat_p = 1'b1;
          else frac_p = frac_q + 1'b1;
        end
      end else begin
        dropped_p = 1'b1;
        if (!in_frac) begin
          if (drop_q == COUNT_MAX) sat_p = 1'b1;
          else drop_p = drop_q + 1'b1;
        end
      end
    end

    if (take_exp) begin
      if (exp_prod > {4'd0, EXP_MAX}) begin
        expv_p = EXP_MAX;
        sat_p  = 1'b1;
      end else begin
        expv_p = exp_prod[EXPV_W-1:0];
      end
    end
  end

  // net exponent from the updated state
  always_comb begin
    exp_s   = $signed({3'b000, expv_p});
    if (exp_minus_p) exp_s = -exp_s;
    exp_net = exp_s + $signed({9'd0, drop_p}) - $signed({9'd0, frac_p});
    sat_out = sat_p;
    exp_clamp = exp_net;
    if (exp_net > ExpMaxS) begin
      exp_clamp = ExpMaxS;
      sat_out   = 1'b1;
    end else if (exp_net < -ExpMaxS) begin
      exp_clamp = -ExpMaxS;
      sat_out   = 1'b1;
    end
    out_data_d = {2'b00, sat_out, dropped_p, exp_clamp[EXPO_W-1:0], acc_p, minus_p};
  end

  assign emit_now = (phase_q != PH_WAIT) && (is_nul || in_last_q);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign advance  = in_valid_q && (!emit_now || out_free);

  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    phase_d = phase_p;
    if (emit_now) phase_d = (is_nul && !in_last_q) ? PH_WAIT : PH_SKIP;
    else if (phase_q == PH_WAIT) phase_d = in_last_q ? PH_SKIP : PH_WAIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SKIP;
      minus_q     <= 1'b0;
      acc_q       <= '0;
      sig_q       <= '0;
      frac_q      <= '0;
      drop_q      <= '0;
      expv_q      <= '0;
      exp_minus_q <= 1'b0;
      dropped_q   <= 1'b0;
      sat_q       <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      if (emit_now || phase_q == PH_WAIT) begin
        minus_q     <= 1'b0;
        acc_q       <= '0;
        sig_q       <= '0;
        frac_q      <= '0;
        drop_q      <= '0;
        expv_q      <= '0;
        exp_minus_q <= 1'b0;
        dropped_q   <= 1'b0;
        sat_q       <= 1'b0;
      end else begin
        minus_q     <= minus_p;
        acc_q       <= acc_p;
        sig_q       <= sig_p;
        frac_q      <= frac_p;
        drop_q      <= drop_p;
        expv_q      <= expv_p;
        exp_minus_q <= exp_minus_p;
        dropped_q   <= dropped_p;
        sat_q       <= sat_p;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit_now) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit_now) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

[tb/tb_decimal_scientific_text_parser_top.sv]
// Testbench for decimal_scientific_text_parser_top: streams text bytes, predicts
// the parsed sign, mantissa, exponent and flags per string, and checks each
// result word in order. Depends on dstp_pkg and the parser top level.
module tb_decimal_scientific_text_parser_top;
  import dstp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef logic [7:0] text_q_t[$];

  typedef struct packed {
    logic                     neg;
    logic [MANT_W-1:0]        mant;
    logic signed [EXPO_W-1:0] expo;
    logic                     dropped;
    logic                     sat;
  } number_fields_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_tvalid = 1'b0;
  logic [7:0]       s_tdata = '0;
  logic             s_tlast = 1'b0;
  logic             s_tready;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  number_fields_t pending_results[$];
  int             err_cnt = 0;
  int             cycle_cnt = 0;
  int             useful_cnt = 0;
  bit             no_idle = 1'b0;

  // predictor state
  phase_e            sc_phase = PH_SKIP;
  logic              sc_minus = 1'b0;
  logic [MANT_W-1:0] sc_acc = '0;
  logic [SIG_W-1:0]  sc_sig = '0;
  logic [CNT_W-1:0]  sc_frac = '0;
  logic [CNT_W-1:0]  sc_drop_int = '0;
  logic [EXPV_W-1:0] sc_exp = '0;
  logic              sc_exp_minus = 1'b0;
  logic              sc_dropped = 1'b0;
  logic              sc_sat = 1'b0;

  decimal_scientific_text_parser_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 19);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void clear_scan();
    sc_phase = PH_SKIP;
    sc_minus = 1'b0;
    sc_acc = '0;
    sc_sig = '0;
    sc_frac = '0;
    sc_drop_int = '0;
    sc_exp = '0;
    sc_exp_minus = 1'b0;
    sc_dropped = 1'b0;
    sc_sat = 1'b0;
  endfunction

  function automatic void bump(inout logic [CNT_W-1:0] n);
    if (n >= COUNT_MAX) sc_sat = 1'b1;
    else n = n + 1'b1;
  endfunction

  function automatic void take_mant_digit(input logic [3:0] d, input logic in_frac);
    if (sc_acc == '0 && d == 4'd0) begin
      if (in_frac) bump(sc_frac);
      return;
    end
    if (sc_sig < MANT_DIGITS) begin
      sc_acc = sc_acc * 10 + d;
      sc_sig = sc_sig + 1'b1;
      if (in_frac) bump(sc_frac);
    end else begin
      sc_dropped = 1'b1;
      if (!in_frac) bump(sc_drop_int);
    end
  endfunction

  function automatic void take_exp_digit(input logic [3:0] d);
    int v;
    v = int'(sc_exp) * 10 + int'(d);
    if (v > int'(EXP_MAX)) begin
      v = int'(EXP_MAX);
      sc_sat = 1'b1;
    end
    sc_exp = v[EXPV_W-1:0];
  endfunction

  function automatic void feed_char(input logic [7:0] c);
    logic       digit;
    logic [3:0] d;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = 4'(c - CH_ZERO);
    if (sc_phase == PH_SKIP) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
      sc_phase = PH_INT;
      if (c == CH_MINUS || c == CH_PLUS) begin
        sc_minus = (c == CH_MINUS);
        return;
      end
    end
    case (sc_phase)
      PH_INT: begin
        if (digit) take_mant_digit(d, 1'b0);
        else if (c == CH_DOT) sc_phase = PH_FRAC;
        else if (c == CH_E_LO || c == CH_E_UP) sc_phase = PH_EXPSIGN;
        else sc_phase = PH_DONE;
      end
      PH_FRAC: begin
        if (digit) take_mant_digit(d, 1'b1);
        else if (c == CH_E_LO || c == CH_E_UP) sc_phase = PH_EXPSIGN;
        else sc_phase = PH_DONE;
      end
      PH_EXPSIGN: begin
        if (c == CH_MINUS || c == CH_PLUS) begin
          sc_exp_minus = (c == CH_MINUS);
          sc_phase = PH_EXPDIG;
        end else if (digit) begin
          take_exp_digit(d);
          sc_phase = PH_EXPDIG;
        end else begin
          sc_phase = PH_DONE;
        end
      end
      PH_EXPDIG: begin
        if (digit) take_exp_digit(d);
        else sc_phase = PH_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic number_fields_t scan_result();
    number_fields_t r;
    int             e;
    e = sc_exp_minus ? -int'(sc_exp) : int'(sc_exp);
    r.sat = sc_sat;
    e = e + int'(sc_drop_int) - int'(sc_frac);
    if (e > int'(EXP_MAX)) begin
      e = int'(EXP_MAX);
      r.sat = 1'b1;
    end
    if (e < -int'(EXP_MAX)) begin
      e = -int'(EXP_MAX);
      r.sat = 1'b1;
    end
    r.neg = sc_minus;
    r.mant = sc_acc;
    r.expo = e[EXPO_W-1:0];
    r.dropped = sc_dropped;
    return r;
  endfunction

  // One accepted byte: update the parse and queue the result at a string end.
  function automatic void scan_byte(input logic [7:0] c, input logic last);
    if (sc_phase == PH_WAIT) begin
      if (last) clear_scan();
      return;
    end
    if (sc_phase != PH_DONE) useful_cnt++;
    if (c == CH_NUL) begin
      pending_results.push_back(scan_result());
      clear_scan();
      if (!last) sc_phase = PH_WAIT;
      return;
    end
    feed_char(c);
    if (last) begin
      pending_results.push_back(scan_result());
      clear_scan();
    end
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    while (!no_idle && $urandom_range(99) < 19) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    scan_byte(c, last);
  endtask

  task automatic send_bytes(input text_q_t q);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
  endtask

  function automatic void append_text(ref text_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  task automatic send_text(input string s);
    text_q_t q;
    append_text(q, s);
    send_bytes(q);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'(($urandom_range(3) == 0) ? 0 : $urandom_range(9));
  endfunction

  always @(posedge clk_i) begin : result_check
    number_fields_t got;
    number_fields_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.neg = m_tdata[0];
      got.mant = m_tdata[60:1];
      got.expo = m_tdata[75:61];
      got.dropped = m_tdata[76];
      got.sat = m_tdata[77];
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result word %h", m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.neg !== want.neg || got.mant !== want.mant || got.expo !== want.expo ||
            got.dropped !== want.dropped || got.sat !== want.sat) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch: exp neg=%0d mant=%0d e=%0d drop=%0d sat=%0d",
                     want.neg, want.mant, want.expo, want.dropped, want.sat);
            $display("          got neg=%0d mant=%0d e=%0d drop=%0d sat=%0d",
                     got.neg, got.mant, got.expo, got.dropped, got.sat);
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_text(" \t-12.50e+3");
    send_text("+0.00e-0");
    send_text("E5");
    send_text("-.e");
    send_bytes({CH_NUL});
    send_bytes({8'h37, CH_NUL, 8'h39, 8'hFF});
    send_text("3x9");
    send_text("\n4.2E-1");
  endtask

  task automatic test_limits();
    text_q_t q;
    // capacity: extra integer digits raise the exponent, extra fraction digits vanish
    send_text("123456789012345678901234.5678e-2");
    send_text("000.000123");
    // fraction count saturates on leading zeros
    q = {};
    q.push_back(CH_DOT);
    repeat (300) q.push_back(CH_ZERO);
    q.push_back(8'h37);
    send_bytes(q);
    // dropped integer count saturates
    q = {};
    repeat (18) q.push_back(8'h39);
    repeat (260) q.push_back(8'h31);
    send_bytes(q);
    send_text("1e123456");
    send_text("99999999999999999999e16383");
    send_text("-0.5e-16383");
  endtask

  task automatic test_random();
    text_q_t q;
    int      pick;
    int      tail;
    int      start_cnt;
    start_cnt = useful_cnt;
    while (useful_cnt < 900) begin
      no_idle = (useful_cnt >= start_cnt + 40 && useful_cnt < start_cnt + 140);
      q = {};
      pick = $urandom_range(99);
      if (pick < 12) begin
        repeat ($urandom_range(6, 1)) q.push_back(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(2))
          q.push_back($urandom_range(1) ? CH_SPACE : 8'($urandom_range(13, 9)));
        case ($urandom_range(2))
          1: q.push_back(CH_PLUS);
          2: q.push_back(CH_MINUS);
          default: ;
        endcase
        repeat (($urandom_range(9) == 0) ? $urandom_range(24, 16) : $urandom_range(6))
          q.push_back(rand_digit());
        if ($urandom_range(1)) begin
          q.push_back(CH_DOT);
          repeat (($urandom_range(9) == 0) ? $urandom_range(22, 15) : $urandom_range(6))
            q.push_back(rand_digit());
        end
        if ($urandom_range(99) < 40) begin
          q.push_back($urandom_range(1) ? CH_E_LO : CH_E_UP);
          case ($urandom_range(2))
            1: q.push_back(CH_PLUS);
            2: q.push_back(CH_MINUS);
            default: ;
          endcase
          repeat ($urandom_range(5)) q.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
        if ($urandom_range(9) == 0 && q.size() > 0)
          q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
      end
      tail = $urandom_range(99);
      if (tail < 15) begin
        repeat ($urandom_range(3, 1)) q.push_back(8'($urandom_range(255, 1)));
      end else if (tail < 30) begin
        q.push_back(CH_NUL);
        repeat ($urandom_range(2)) q.push_back(8'($urandom_range(255)));
      end
      if (q.size() == 0) q.push_back(CH_NUL);
      send_bytes(q);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limits();
    test_random();
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    err_cnt += pending_results.size();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
